/* src/point_line_side_counter_macros.svh */
// Assertion macros for the point line side counter.
`ifndef POINT_LINE_SIDE_COUNTER_MACROS_SVH
`define POINT_LINE_SIDE_COUNTER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PLC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plc assertion failed");

// Next-cycle implication, disabled in reset.
`define PLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plc assertion failed");

// Next-cycle implication that also holds through reset.
`define PLC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("plc assertion failed");

`endif

/* src/plc_pkg.sv */
// Package: types, constants and helpers of the point line side counter.
`default_nettype none
package plc_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int COORD_BITS_DEF = 16;
    localparam int FIELD_W        = 16;
    localparam int IN_DATA_W      = 2 * FIELD_W;
    localparam int TALLY_W        = 12;
    localparam int THRESH_W       = 12;
    localparam int OUT_USED_W     = 3 * TALLY_W + 2;
    localparam int OUT_DATA_W     = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W      = OUT_DATA_W - OUT_USED_W;
    localparam int MIN_POINTS     = 3;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(14);
    localparam logic [TALLY_W-1:0]  TALLY_MAX    = '1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ_I,
        ST_READ_J,
        ST_SETUP,
        ST_SWEEP,
        ST_DRAIN,
        ST_NEXT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic valid;
        logic zero;
        logic neg;
    } t_side;

    function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] t);
        return (t == TALLY_MAX) ? t : t + TALLY_W'(1);
    endfunction

endpackage
`default_nettype wire

/* src/point_line_side_counter.sv */
// Top level: point loader, triple walk sequencer, tallies and result register.
//
// Usage:
//   Slave stream carries one point per transfer: tdata holds point_x in
//   bits 15:0 and point_y in bits 31:16, tlast marks the final point of a set.
//   Points load one per cycle into the point memory. Points beyond the
//   memory depth are dropped and flagged in the result.
//   The transfer with tlast starts the walk over all ordered pairs (i, j)
//   and third points z; the slave side is not ready during the walk.
//   The walk reads one third point per cycle through the single read port
//   of the point memory; with fewer than three points the walk is skipped
//   and the result goes to the output register once it is free.
//   The master stream then carries one result transfer. The result sits in
//   an output register, so loading of the next set starts at once even
//   while the receiver stalls; a stalled result only holds up the end of
//   the next walk.
//   The configuration channel writes count_threshold at any time, always
//   ready; it takes effect on the next result.
//   Reset (synchronous, active low) empties the point set, clears the
//   tallies and the result, and sets count_threshold to 14.
`default_nettype none
module point_line_side_counter #(
    parameter int MAX_POINTS = plc_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = plc_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // point_x [15:0], point_y [31:16]
    input  logic [plc_pkg::IN_DATA_W-1:0]     i_s_tdata,
    input  logic                              i_s_tlast,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // on_line_count [11:0], negative_side_count [23:12],
    // positive_side_count [35:24], all_exceed [36], set_overflow [37], zero
    output logic [plc_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [plc_pkg::THRESH_W-1:0]      i_cfg_data
);
    import plc_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int PT_W  = 2 * COORD_BITS;

    t_state                   r_state;
    t_state                   n_state;
    logic [CNT_W-1:0]         r_held;
    logic                     r_ovf;
    logic [IDX_W-1:0]         r_i;
    logic [IDX_W-1:0]         r_j;
    logic [IDX_W-1:0]         r_z;
    logic                     r_sv;
    logic [TALLY_W-1:0]       r_zero_t;
    logic [TALLY_W-1:0]       r_neg_t;
    logic [TALLY_W-1:0]       r_pos_t;
    logic [THRESH_W-1:0]      r_thresh;
    logic                     r_out_valid;
    logic [OUT_DATA_W-1:0]    r_out_data;
    logic signed [COORD_BITS-1:0] r_xi;
    logic signed [COORD_BITS-1:0] r_yi;
    logic signed [COORD_BITS:0]   r_a;
    logic signed [COORD_BITS:0]   r_b;

    logic                     w_s_acc;
    logic                     w_room;
    logic [CNT_W-1:0]         w_held_next;
    logic [CNT_W-1:0]         w_held_m1;
    logic [IDX_W-1:0]         w_last_idx;
    logic                     w_out_free;
    logic [IDX_W-1:0]         w_ni;
    logic [IDX_W-1:0]         w_nj;
    logic [IDX_W-1:0]         w_rd_addr;
    logic [PT_W-1:0]          w_rd_data;
    logic [PT_W-1:0]          w_wr_data;
    logic [COORD_BITS-1:0]    w_in_x;
    logic [COORD_BITS-1:0]    w_in_y;
    logic signed [COORD_BITS-1:0] w_rd_x;
    logic signed [COORD_BITS-1:0] w_rd_y;
    logic                     w_all;
    t_side                    w_side;
    logic                     w_eval_busy;

    assign o_s_tready  = (r_state == ST_LOAD);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    assign w_s_acc     = i_s_tvalid && o_s_tready;
    assign w_room      = (r_held < CNT_W'(MAX_POINTS));
    assign w_held_next = w_room ? r_held + CNT_W'(1) : r_held;
    assign w_held_m1   = r_held - CNT_W'(1);
    assign w_last_idx  = w_held_m1[IDX_W-1:0];
    assign w_out_free  = !r_out_valid || i_m_tready;

    // coordinate field: low COORD_BITS bits, zero-filled above the field
    assign w_in_x    = COORD_BITS'(i_s_tdata[FIELD_W-1:0]);
    assign w_in_y    = COORD_BITS'(i_s_tdata[IN_DATA_W-1:FIELD_W]);
    assign w_wr_data = {w_in_y, w_in_x};
    assign w_rd_x    = w_rd_data[COORD_BITS-1:0];
    assign w_rd_y    = w_rd_data[PT_W-1:COORD_BITS];

    assign w_all = (r_zero_t > r_thresh) && (r_neg_t > r_thresh) && (r_pos_t > r_thresh);

    always_comb begin
        if (r_j == w_last_idx) begin
            w_nj = '0;
            w_ni = r_i + IDX_W'(1);
        end else begin
            w_nj = r_j + IDX_W'(1);
            w_ni = r_i;
        end
    end

    always_comb begin
        n_state   = r_state;
        w_rd_addr = r_z;
        unique case (r_state)
            ST_LOAD: begin
                if (w_s_acc && i_s_tlast) begin
                    n_state = (w_held_next < CNT_W'(MIN_POINTS)) ? ST_DONE : ST_READ_I;
                end
            end
            ST_READ_I: begin
                w_rd_addr = r_i;
                n_state   = ST_READ_J;
            end
            ST_READ_J: begin
                w_rd_addr = r_j;
                n_state   = ST_SETUP;
            end
            ST_SETUP: begin
                n_state = ST_SWEEP;
            end
            ST_SWEEP: begin
                if (r_z == w_last_idx) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_sv && !w_eval_busy) begin
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (r_i == w_last_idx && r_j == w_last_idx) begin
                    n_state = ST_DONE;
                end else if (w_ni != w_nj) begin
                    n_state = ST_READ_I;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_held      <= '0;
            r_ovf       <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_z         <= '0;
            r_sv        <= 1'b0;
            r_zero_t    <= '0;
            r_neg_t     <= '0;
            r_pos_t     <= '0;
            r_thresh    <= THRESH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sv    <= (r_state == ST_SWEEP) && (r_z != r_i) && (r_z != r_j);
            if (i_cfg_valid) begin
                r_thresh <= i_cfg_data;
            end
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_side.valid) begin
                priority if (w_side.zero) begin
                    r_zero_t <= sat_inc(r_zero_t);
                end else if (w_side.neg) begin
                    r_neg_t <= sat_inc(r_neg_t);
                end else begin
                    r_pos_t <= sat_inc(r_pos_t);
                end
            end
            unique case (r_state)
                ST_LOAD: begin
                    if (w_s_acc) begin
                        r_held <= w_held_next;
                        if (!w_room) begin
                            r_ovf <= 1'b1;
                        end
                        if (i_s_tlast) begin
                            r_zero_t <= '0;
                            r_neg_t  <= '0;
                            r_pos_t  <= '0;
                            r_i      <= '0;
                            r_j      <= IDX_W'(1);
                        end
                    end
                end
                ST_SETUP: begin
                    r_z <= '0;
                end
                ST_SWEEP: begin
                    r_z <= r_z + IDX_W'(1);
                end
                ST_NEXT: begin
                    r_i <= w_ni;
                    r_j <= w_nj;
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_held      <= '0;
                        r_ovf       <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ_J) begin
            r_xi <= w_rd_x;
            r_yi <= w_rd_y;
        end
        if (r_state == ST_SETUP) begin
            r_a <= (COORD_BITS + 1)'(r_yi) - (COORD_BITS + 1)'(w_rd_y);
            r_b <= (COORD_BITS + 1)'(w_rd_x) - (COORD_BITS + 1)'(r_xi);
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_out_data <= {OUT_PAD_W'(0), r_ovf, w_all, r_pos_t, r_neg_t, r_zero_t};
        end
    end

    plc_point_mem #(
        .DEPTH  (MAX_POINTS),
        .WIDTH  (PT_W),
        .ADDR_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_s_acc && w_room),
        .i_wr_addr (r_held[IDX_W-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    plc_side_eval #(
        .COORD_BITS (COORD_BITS)
    ) u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_sv),
        .i_point (w_rd_data),
        .i_xi    (r_xi),
        .i_yi    (r_yi),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_side  (w_side),
        .o_busy  (w_eval_busy)
    );

endmodule
`default_nettype wire

/* src/plc_point_mem.sv */
// Point store: one write port, one read port with registered read data.
`default_nettype none
module plc_point_mem #(
    parameter int DEPTH  = plc_pkg::MAX_POINTS_DEF,
    parameter int WIDTH  = 2 * plc_pkg::COORD_BITS_DEF,
    parameter int ADDR_W = $clog2(plc_pkg::MAX_POINTS_DEF)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

/* src/plc_side_eval.sv */
// Two-stage side test: a*(xz-xi) + b*(yz-yi), then sign and zero classification.
`default_nettype none
module plc_side_eval #(
    parameter int COORD_BITS = plc_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [2*COORD_BITS-1:0]      i_point,
    input  logic signed [COORD_BITS-1:0] i_xi,
    input  logic signed [COORD_BITS-1:0] i_yi,
    input  logic signed [COORD_BITS:0]   i_a,
    input  logic signed [COORD_BITS:0]   i_b,
    output plc_pkg::t_side               o_side,
    output logic                         o_busy
);
    import plc_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    logic signed [COORD_BITS-1:0] w_xz;
    logic signed [COORD_BITS-1:0] w_yz;
    logic signed [DW-1:0]         w_dx;
    logic signed [DW-1:0]         w_dy;
    logic signed [PW-1:0]         w_p1;
    logic signed [PW-1:0]         w_p2;
    logic signed [SW-1:0]         w_sum;

    logic                         r_v1;
    logic signed [PW-1:0]         r_p1;
    logic signed [PW-1:0]         r_p2;
    logic                         r_v2;
    logic                         r_zero;
    logic                         r_neg;

    assign w_xz  = i_point[COORD_BITS-1:0];
    assign w_yz  = i_point[2*COORD_BITS-1:COORD_BITS];
    assign w_dx  = DW'(w_xz) - DW'(i_xi);
    assign w_dy  = DW'(w_yz) - DW'(i_yi);
    assign w_p1  = i_a * w_dx;
    assign w_p2  = i_b * w_dy;
    assign w_sum = SW'(r_p1) + SW'(r_p2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1   <= w_p1;
        r_p2   <= w_p2;
        r_zero <= (w_sum == '0);
        r_neg  <= w_sum[SW-1];
    end

    always_comb begin
        o_side.valid = r_v2;
        o_side.zero  = r_zero;
        o_side.neg   = r_neg;
    end

    assign o_busy = r_v1 | r_v2;

endmodule
`default_nettype wire

/* src/plc_checker.sv */
// Port-level checks of the point line side counter, bound to the top level.
`default_nettype none
`include "point_line_side_counter_macros.svh"
module plc_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_s_tvalid,
    input wire logic                           o_s_tready,
    input wire logic                           i_s_tlast,
    input wire logic                           o_m_tvalid,
    input wire logic                           i_m_tready,
    input wire logic [plc_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input wire logic                           i_cfg_valid,
    input wire logic                           o_cfg_ready
);
    import plc_pkg::*;

    logic w_last_acc;
    logic w_out_stall;
    logic w_flag_shown;
    logic w_counts_nz;
    logic w_idle_ok;

    assign w_last_acc   = i_s_tvalid && o_s_tready && i_s_tlast;
    assign w_out_stall  = o_m_tvalid && !i_m_tready;
    assign w_flag_shown = o_m_tvalid && o_m_tdata[3*TALLY_W];
    assign w_counts_nz  = (o_m_tdata[TALLY_W-1:0] != '0) &&
                          (o_m_tdata[2*TALLY_W-1:TALLY_W] != '0) &&
                          (o_m_tdata[3*TALLY_W-1:2*TALLY_W] != '0);
    assign w_idle_ok    = !o_m_tvalid && o_s_tready;

    `PLC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_m_tvalid && $stable(o_m_tdata))
    `PLC_ASSERT_NEXT(a_walk_blocks_load, i_clk, i_rst_n, w_last_acc, !o_s_tready)
    `PLC_ASSERT_IMPLY(a_flag_needs_counts, i_clk, i_rst_n, w_flag_shown, w_counts_nz)
    `PLC_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, w_idle_ok)
    `PLC_ASSERT_IMPLY(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready)

endmodule

bind point_line_side_counter plc_checker u_plc_checker (.*);
`default_nettype wire

/* dv/side_count_checker.sv */
// Checker for point_line_side_counter: tracks point sets, predicts side counts, compares results.
module side_count_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // point_x [15:0], point_y [31:16]
    input  logic [plc_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic                           i_s_tlast,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // on_line_count [11:0], negative_side_count [23:12],
    // positive_side_count [35:24], all_exceed [36], set_overflow [37], zero
    input  logic [plc_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [plc_pkg::THRESH_W-1:0]   i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = plc_pkg::MAX_POINTS_DEF;
    localparam int TW    = plc_pkg::TALLY_W;

    // packed from the top bit down, so on_line lands in the lowest bits
    typedef struct packed {
        logic          set_overflow;
        logic          all_exceed;
        logic [TW-1:0] pos_side;
        logic [TW-1:0] neg_side;
        logic [TW-1:0] on_line;
    } side_counts_t;

    longint                      x_held [DEPTH];
    longint                      y_held [DEPTH];
    int                          held;
    logic                        dropped;
    logic [plc_pkg::THRESH_W-1:0] threshold;
    side_counts_t                expected_counts [$];

    function automatic logic [TW-1:0] bump(input logic [TW-1:0] t);
        return (t == '1) ? t : t + 1'b1;
    endfunction

    // Walk every ordered pair (i, j), i != j, and every third point z.
    function automatic side_counts_t count_sides();
        side_counts_t r;
        longint a, b, c, v;
        r = '0;
        for (int i = 0; i < held; i++) begin
            for (int j = 0; j < held; j++) begin
                if (j != i) begin
                    a = y_held[i] - y_held[j];
                    b = x_held[j] - x_held[i];
                    c = (x_held[i] - x_held[j]) * y_held[i]
                      + (y_held[j] - y_held[i]) * x_held[i];
                    for (int z = 0; z < held; z++) begin
                        if (z != i && z != j) begin
                            v = a * x_held[z] + b * y_held[z] + c;
                            if (v == 0)
                                r.on_line = bump(r.on_line);
                            else if (v < 0)
                                r.neg_side = bump(r.neg_side);
                            else
                                r.pos_side = bump(r.pos_side);
                        end
                    end
                end
            end
        end
        r.all_exceed = (r.on_line > threshold) && (r.neg_side > threshold) &&
                       (r.pos_side > threshold);
        r.set_overflow = dropped;
        return r;
    endfunction

    always @(posedge i_clk) begin
        side_counts_t got, want;
        logic [plc_pkg::OUT_PAD_W-1:0] pad;
        if (!i_rst_n) begin
            held      = 0;
            dropped   = 1'b0;
            threshold = plc_pkg::THRESH_RESET;
            expected_counts.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                threshold = i_cfg_data;
            if (i_s_tvalid && i_s_tready) begin
                if (held < DEPTH) begin
                    x_held[held] = longint'($signed(i_s_tdata[15:0]));
                    y_held[held] = longint'($signed(i_s_tdata[31:16]));
                    held++;
                end else begin
                    dropped = 1'b1;
                end
                if (i_s_tlast) begin
                    expected_counts.push_back(count_sides());
                    held    = 0;
                    dropped = 1'b0;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[plc_pkg::OUT_USED_W-1:0];
                pad = i_m_tdata[plc_pkg::OUT_DATA_W-1:plc_pkg::OUT_USED_W];
                if (expected_counts.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: result with no set pending: z=%0d n=%0d p=%0d",
                                 $realtime, got.on_line, got.neg_side, got.pos_side);
                    o_fail_count++;
                end else begin
                    want = expected_counts.pop_front();
                    if (got !== want || pad !== '0) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: result %0d expected z=%0d n=%0d p=%0d all=%0b ovf=%0b",
                                     $realtime, o_checked, want.on_line, want.neg_side,
                                     want.pos_side, want.all_exceed, want.set_overflow);
                            $display("%0t: result %0d got z=%0d n=%0d p=%0d all=%0b ovf=%0b pad=%0h",
                                     $realtime, o_checked, got.on_line, got.neg_side,
                                     got.pos_side, got.all_exceed, got.set_overflow, pad);
                        end
                        o_fail_count++;
                    end
                end
                o_checked++;
            end
        end
        o_pending = expected_counts.size();
    end

endmodule

/* dv/point_line_side_counter_test.sv */
// Testbench top for point_line_side_counter: clock, reset, point and config stimulus, verdict.
module point_line_side_counter_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES          = 6;
    localparam int POINTS_PER_PHASE = 200;
    localparam int IDLE_LIMIT      = 40000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int GAP_PLAN   [PHASES] = '{25, 0, 15, 40, 10, 0};
    localparam int STALL_PLAN [PHASES] = '{0, 40, 15, 40, 5, 0};

    typedef enum logic [1:0] {
        SHAPE_WIDE,
        SHAPE_GRID,
        SHAPE_LINE,
        SHAPE_CORNERS
    } point_shape_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [plc_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                           s_tlast;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [plc_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [plc_pkg::THRESH_W-1:0]   cfg_data;

    int fail_count;
    int pending;
    int checked;
    int points_sent;
    int sets_sent;
    int thresholds_written;
    int gap_pct;
    int stall_pct;
    bit calm;
    int idle_cycles;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    point_line_side_counter DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    side_count_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // Watchdog on cycles without any transfer.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Result receiver with random stall bursts.
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0 && !calm) begin
                m_tready = 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
                m_tready   = 1'b0;
                stall_left = $urandom_range(1, 13) - 1;
            end else begin
                m_tready   = 1'b1;
                stall_left = 0;
            end
        end
    end

    task automatic send_point(input logic [15:0] px, input logic [15:0] py,
                              input logic last);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {py, px};
        s_tlast  = last;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;
        points_sent++;
        if (last)
            sets_sent++;
    endtask

    task automatic write_threshold(input logic [plc_pkg::THRESH_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        thresholds_written++;
    endtask

    task automatic wait_idle();
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_random_set();
        point_shape_t shape;
        int           n;
        int           pick;
        logic [15:0]  px, py, bx, by, dx, dy;
        logic [15:0]  corner [5];
        corner = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0001};
        pick   = $urandom_range(0, 99);
        if (pick < 70)
            n = $urandom_range(1, 7);
        else if (pick < 92)
            n = $urandom_range(8, 16);
        else
            n = $urandom_range(17, 20);
        shape = point_shape_t'($urandom_range(0, 3));
        bx = 16'($urandom);
        by = 16'($urandom);
        dx = 16'($urandom_range(0, 8)) - 16'd4;
        dy = 16'($urandom_range(0, 8)) - 16'd4;
        for (int k = 0; k < n; k++) begin
            case (shape)
                SHAPE_WIDE: begin
                    px = 16'($urandom);
                    py = 16'($urandom);
                end
                SHAPE_GRID: begin
                    px = 16'($urandom_range(0, 6)) - 16'd3;
                    py = 16'($urandom_range(0, 6)) - 16'd3;
                end
                SHAPE_LINE: begin
                    px = bx + 16'(k) * dx;
                    py = by + 16'(k) * dy;
                    if ($urandom_range(0, 4) == 0)
                        py = py + 16'($urandom_range(1, 3));
                end
                default: begin
                    px = corner[$urandom_range(0, 4)];
                    py = corner[$urandom_range(0, 4)];
                end
            endcase
            send_point(px, py, k == n - 1);
        end
    endtask

    initial begin
        int phase_start;
        logic [plc_pkg::THRESH_W-1:0] next_threshold;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        calm      = 1'b0;
        gap_pct   = 20;
        stall_pct = 20;
        points_sent        = 0;
        sets_sent          = 0;
        thresholds_written = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed sets, threshold at its reset value.
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h7FFF, 16'h7FFF, 1'b0);
        send_point(16'h8000, 16'h7FFF, 1'b0);
        send_point(16'h7FFF, 16'h8000, 1'b0);
        send_point(16'h0000, 16'h0000, 1'b1);
        send_point(16'h0001, 16'h0002, 1'b1);      // single point, no triples
        send_point(16'h0000, 16'h0000, 1'b0);      // collinear
        send_point(16'h0001, 16'h0001, 1'b0);
        send_point(16'h0002, 16'h0002, 1'b1);
        for (int k = 0; k < 17; k++)               // store full, last point dropped
            send_point(16'(k * 4099), 16'(-k * 2053), k == 16);

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0:       next_threshold = '0;
                1:       next_threshold = '1;
                5:       next_threshold = plc_pkg::THRESH_RESET;
                3:       next_threshold = 12'($urandom_range(1, 20));
                default: next_threshold = 12'($urandom_range(0, 4095));
            endcase
            write_threshold(next_threshold);
            gap_pct   = GAP_PLAN[p];
            stall_pct = STALL_PLAN[p];
            calm      = (p == PHASES - 1);
            phase_start = points_sent;
            while (points_sent - phase_start < POINTS_PER_PHASE)
                send_random_set();
        end
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Run covered %0d points in %0d sets, %0d results compared, %0d threshold writes.",
                 points_sent, sets_sent, checked, thresholds_written);
        $display("Sets spanned 1 to 20 points, overflow included, with corner, grid and line data.");
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/plc_pkg.sv
src/plc_point_mem.sv
src/plc_side_eval.sv
src/point_line_side_counter.sv
src/plc_checker.sv
dv/side_count_checker.sv
dv/point_line_side_counter_test.sv
